>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent true implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent true implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/mcsr_pkg.sv
package mcsr_pkg;

   localparam int DATA_W      = 32;
   localparam int SIZE_W      = 4;
   localparam int COORD_W     = 3;
   localparam int RSP_TDATA_W = 40;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

   // sequencer states, one-hot
   typedef enum logic [13:0] {
      ST_LOAD     = 14'b00000000000001,
      ST_SRT_RD0  = 14'b00000000000010,
      ST_SRT_CUR  = 14'b00000000000100,
      ST_SRT_RD   = 14'b00000000001000,
      ST_SRT_CMP  = 14'b00000000010000,
      ST_SRT_WR   = 14'b00000000100000,
      ST_RK_RD    = 14'b00000001000000,
      ST_RK_KEY   = 14'b00000010000000,
      ST_RK_DRD   = 14'b00000100000000,
      ST_RK_CMP   = 14'b00001000000000,
      ST_RK_WR    = 14'b00010000000000,
      ST_EM_RD    = 14'b00100000000000,
      ST_EM_WAIT  = 14'b01000000000000,
      ST_EM_HOLD  = 14'b10000000000000
   } state_type;

endpackage

>>> rtl/matrix_column_sort_reorder_top.sv
// sequence: the n*n elements load first, then each column is bubble sorted, the columns are
// ranked by their bottom value, and the results are emitted while rsp_tready is high
// throughput: one matrix of n*n requests per pass, a request is taken every cycle while
// loading; the element ram has one write and one read port and the 32-bit compare is shared
// reset: synchronous, active high; size returns to 8, load position clears, column order
// returns to identity; the element ram is not cleared
`include "assert_macros.svh"

module matrix_column_sort_reorder_top
   import mcsr_pkg::*;
#(
   parameter int MAX_DIM = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // size register write
   input  logic                   csr_wr_en,
   input  logic [SIZE_W-1:0]      csr_wr_data,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [DATA_W-1:0]      req_tdata,   // [31:0] element_value
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [31:0] result_value, [34:32] result_row,
                                               // [37:35] result_col, [39:38] zero
   output logic                   rsp_tlast    // end_of_matrix
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W  = $clog2(MAX_DIM);
   localparam int CNT_W  = $clog2(MAX_DIM + 1);

   // row-major slot of element (r, c)
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
      cell_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM)) + ADDR_W'(c);
   endfunction

   state_type          state_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [IDX_W-1:0]   row_ff;     // load row, emit row
   logic [IDX_W-1:0]   col_ff;     // load col, sorted column, ranked column, emit col
   logic [IDX_W-1:0]   pass_ff;    // bubble pass
   logic [IDX_W-1:0]   pos_ff;     // bubble position, rank partner column
   logic [IDX_W-1:0]   rank_ff;
   logic [DATA_W-1:0]  cur_ff;     // running max in a pass, key of ranked column
   logic [IDX_W-1:0]   order_ff [MAX_DIM];

   logic [DATA_W-1:0]      rsp_value_ff;
   logic [IDX_W-1:0]       rsp_row_ff;
   logic [IDX_W-1:0]       rsp_col_ff;
   logic                   rsp_last_ff;
   logic                   rsp_valid_ff;

   // clamped matrix size
   logic [CNT_W-1:0]   dim;
   logic [IDX_W-1:0]   dim_m1;

   always_comb begin
      if (size_ff == '0) begin
         dim = CNT_W'(1);
      end else if (size_ff > SIZE_W'(MAX_DIM)) begin
         dim = CNT_W'(MAX_DIM);
      end else begin
         dim = CNT_W'(size_ff);
      end
      dim_m1 = IDX_W'(dim - CNT_W'(1));
   end

   // ram ports
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [DATA_W-1:0]  ram_wr_data;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [DATA_W-1:0]  ram_rd_data;

   mcsr_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // shared signed compare: bubble step tests cur > new, rank step tests partner vs key
   logic [DATA_W-1:0]  cmp_a;
   logic [DATA_W-1:0]  cmp_b;
   logic               cmp_gt;
   logic               cmp_eq;

   always_comb begin
      if (state_ff == ST_RK_CMP) begin
         cmp_a = ram_rd_data;
         cmp_b = cur_ff;
      end else begin
         cmp_a = cur_ff;
         cmp_b = ram_rd_data;
      end
      cmp_gt = $signed(cmp_a) > $signed(cmp_b);
      cmp_eq = (cmp_a == cmp_b);
   end

   logic req_fire;
   logic rsp_fire;
   logic pass_end;     // last compare of a bubble pass
   logic rank_hit;     // partner column ranks ahead of the keyed column

   assign req_tready = (state_ff == ST_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;
   assign pass_end   = (IDX_W'(pos_ff + 1'b1) == IDX_W'(dim_m1 - pass_ff));
   assign rank_hit   = cmp_gt || (cmp_eq && (pos_ff < col_ff));

   // ram port selection
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cell_addr(row_ff, col_ff);
      ram_wr_data = req_tdata;
      ram_rd_addr = '0;
      unique case (state_ff)
         ST_LOAD: begin
            ram_wr_en = req_fire && !csr_wr_en;
         end
         ST_SRT_RD0: begin
            ram_rd_addr = cell_addr('0, col_ff);
         end
         ST_SRT_RD: begin
            ram_rd_addr = cell_addr(IDX_W'(pos_ff + 1'b1), col_ff);
         end
         ST_SRT_CMP: begin
            // smaller value drops to the current slot, the max moves on
            ram_wr_en   = 1'b1;
            ram_wr_addr = cell_addr(pos_ff, col_ff);
            ram_wr_data = cmp_gt ? ram_rd_data : cur_ff;
         end
         ST_SRT_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cell_addr(IDX_W'(pos_ff + 1'b1), col_ff);
            ram_wr_data = cur_ff;
         end
         ST_RK_RD: begin
            ram_rd_addr = cell_addr(dim_m1, col_ff);
         end
         ST_RK_DRD: begin
            ram_rd_addr = cell_addr(dim_m1, pos_ff);
         end
         ST_EM_RD: begin
            ram_rd_addr = cell_addr(row_ff, order_ff[col_ff]);
         end
         ST_SRT_CUR, ST_RK_KEY, ST_RK_CMP, ST_RK_WR, ST_EM_WAIT, ST_EM_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         size_ff      <= SIZE_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         pass_ff      <= '0;
         pos_ff       <= '0;
         rank_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_DIM; k++) begin
            order_ff[k] <= IDX_W'(k);
         end
      end else if (csr_wr_en) begin
         // new size drops any partial matrix
         size_ff <= csr_wr_data;
         row_ff  <= '0;
         col_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_LOAD: begin
               if (req_fire) begin
                  if (col_ff == dim_m1) begin
                     col_ff <= '0;
                     if (row_ff == dim_m1) begin
                        row_ff  <= '0;
                        pass_ff <= '0;
                        pos_ff  <= '0;
                        // a one by one matrix needs no column sort
                        state_ff <= (dim_m1 == '0) ? ST_RK_RD : ST_SRT_RD0;
                     end else begin
                        row_ff <= IDX_W'(row_ff + 1'b1);
                     end
                  end else begin
                     col_ff <= IDX_W'(col_ff + 1'b1);
                  end
               end
            end
            ST_SRT_RD0: begin
               pos_ff   <= '0;
               state_ff <= ST_SRT_CUR;
            end
            ST_SRT_CUR: begin
               state_ff <= ST_SRT_RD;
            end
            ST_SRT_RD: begin
               state_ff <= ST_SRT_CMP;
            end
            ST_SRT_CMP: begin
               if (pass_end) begin
                  state_ff <= ST_SRT_WR;
               end else begin
                  pos_ff   <= IDX_W'(pos_ff + 1'b1);
                  state_ff <= ST_SRT_RD;
               end
            end
            ST_SRT_WR: begin
               if (IDX_W'(pass_ff + 1'b1) == dim_m1) begin
                  pass_ff <= '0;
                  if (col_ff == dim_m1) begin
                     col_ff   <= '0;
                     state_ff <= ST_RK_RD;
                  end else begin
                     col_ff   <= IDX_W'(col_ff + 1'b1);
                     state_ff <= ST_SRT_RD0;
                  end
               end else begin
                  pass_ff  <= IDX_W'(pass_ff + 1'b1);
                  state_ff <= ST_SRT_RD0;
               end
            end
            ST_RK_RD: begin
               state_ff <= ST_RK_KEY;
            end
            ST_RK_KEY: begin
               pos_ff   <= '0;
               rank_ff  <= '0;
               state_ff <= ST_RK_DRD;
            end
            ST_RK_DRD: begin
               state_ff <= ST_RK_CMP;
            end
            ST_RK_CMP: begin
               if (rank_hit) begin
                  rank_ff <= IDX_W'(rank_ff + 1'b1);
               end
               if (pos_ff == dim_m1) begin
                  state_ff <= ST_RK_WR;
               end else begin
                  pos_ff   <= IDX_W'(pos_ff + 1'b1);
                  state_ff <= ST_RK_DRD;
               end
            end
            ST_RK_WR: begin
               order_ff[rank_ff] <= col_ff;
               if (col_ff == dim_m1) begin
                  col_ff   <= '0;
                  row_ff   <= '0;
                  state_ff <= ST_EM_RD;
               end else begin
                  col_ff   <= IDX_W'(col_ff + 1'b1);
                  state_ff <= ST_RK_RD;
               end
            end
            ST_EM_RD: begin
               state_ff <= ST_EM_WAIT;
            end
            ST_EM_WAIT: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_EM_HOLD;
            end
            ST_EM_HOLD: begin
               if (rsp_fire) begin
                  rsp_valid_ff <= 1'b0;
                  if (col_ff == dim_m1) begin
                     col_ff <= '0;
                     if (row_ff == dim_m1) begin
                        row_ff   <= '0;
                        state_ff <= ST_LOAD;
                     end else begin
                        row_ff   <= IDX_W'(row_ff + 1'b1);
                        state_ff <= ST_EM_RD;
                     end
                  end else begin
                     col_ff   <= IDX_W'(col_ff + 1'b1);
                     state_ff <= ST_EM_RD;
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   // data registers, no reset
   always_ff @(posedge clock) begin
      if (state_ff == ST_SRT_CUR || state_ff == ST_RK_KEY) begin
         cur_ff <= ram_rd_data;
      end else if (state_ff == ST_SRT_CMP && !cmp_gt) begin
         cur_ff <= ram_rd_data;
      end
      if (state_ff == ST_EM_WAIT) begin
         rsp_value_ff <= ram_rd_data;
         rsp_row_ff   <= row_ff;
         rsp_col_ff   <= col_ff;
         rsp_last_ff  <= (row_ff == dim_m1) && (col_ff == dim_m1);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_valid_ff && rsp_last_ff;
   assign rsp_tdata  = {2'b00, COORD_W'(rsp_col_ff), COORD_W'(rsp_row_ff), rsp_value_ff};

   // checks
   `ASSERT_IMPLIES(a_no_load_while_out, clock, reset, req_tready, !rsp_tvalid,
      "request taken while a result is pending")
   `ASSERT_NEXT(a_ready_after_last, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast,
      req_tready, "not ready for requests after the final result")
   `ASSERT_IMPLIES(a_rank_in_range, clock, reset, state_ff == ST_RK_WR, rank_ff <= dim_m1,
      "column rank beyond matrix size")
   `ASSERT_IMPLIES(a_pass_in_range, clock, reset, state_ff == ST_SRT_CMP,
      pos_ff < dim_m1, "bubble position past the bottom row")

endmodule

>>> rtl/mcsr_ram.sv
module mcsr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
